[hw/rtl/acm_pkg.sv]
// shared types, codes and helpers of the aho-corasick matcher
`timescale 1ns / 1ps
`default_nettype none
package acm_pkg;

    localparam int CNT_W = 16;
    localparam int NODE_OUT_W = 12;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_BUILD  = 2'd2,
        KIND_SCAN   = 2'd3
    } acm_kind_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CNT,
        ST_SCAN_G,
        ST_SCAN_N,
        ST_B_POP,
        ST_B_P,
        ST_B_F,
        ST_B_FC,
        ST_B_C0,
        ST_B_C1,
        ST_B_C2,
        ST_DONE
    } acm_state_t;

    // per-field write enables of the node memory
    typedef struct packed {
        logic fail;
        logic cnt;
        logic q;
    } node_we_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/acm_goto_mem.sv]
// transition table memory, one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module acm_goto_mem #(
    parameter int DEPTH = 106496,
    parameter int AW    = 17,
    parameter int DW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_a,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

[hw/rtl/acm_node_mem.sv]
// per-node memory: failure link, pattern count and queue slot, field write enables
`timescale 1ns / 1ps
`default_nettype none
module acm_node_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                    clk,
    input  wire acm_pkg::node_we_t       we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [AW-1:0]           wfail,
    input  wire logic [acm_pkg::CNT_W-1:0] wcnt,
    input  wire logic [AW-1:0]           wq,
    input  wire logic [AW-1:0]           raddr,
    output logic      [AW-1:0]           rfail,
    output logic      [acm_pkg::CNT_W-1:0] rcnt,
    output logic      [AW-1:0]           rq
);

    logic [AW-1:0]             fail_mem [DEPTH];
    logic [acm_pkg::CNT_W-1:0] cnt_mem  [DEPTH];
    logic [AW-1:0]             q_mem    [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.fail)
        begin
            fail_mem[waddr] <= wfail;
        end
        if (we.cnt)
        begin
            cnt_mem[waddr] <= wcnt;
        end
        if (we.q)
        begin
            q_mem[waddr] <= wq;
        end
        rfail <= fail_mem[raddr];
        rcnt  <= cnt_mem[raddr];
        rq    <= q_mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/acm_seq.sv]
// sequencer: insert, scan, row sweep and breadth-first link build over the memories
`timescale 1ns / 1ps
`default_nettype none
module acm_seq #(
    parameter int MAX_NODES = 4096,
    parameter int ALPHABET  = 26,
    parameter int NW        = 12,
    parameter int CW        = 5,
    parameter int GW        = 17
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire logic [1:0]                kind,
    input  wire logic [4:0]                symbol,
    input  wire logic                      last,
    input  wire logic                      slot_free,
    output logic                           res_load,
    output logic [acm_pkg::CNT_W-1:0]      res_count,
    output logic [NW-1:0]                  res_node,
    output logic                           res_status,
    output logic                           g_we,
    output logic [GW-1:0]                  g_waddr,
    output logic [NW-1:0]                  g_wdata,
    output logic [GW-1:0]                  g_raddr_a,
    output logic [GW-1:0]                  g_raddr_b,
    input  wire logic [NW-1:0]             g_rdata_a,
    input  wire logic [NW-1:0]             g_rdata_b,
    output acm_pkg::node_we_t              n_we,
    output logic [NW-1:0]                  n_waddr,
    output logic [NW-1:0]                  n_wfail,
    output logic [acm_pkg::CNT_W-1:0]      n_wcnt,
    output logic [NW-1:0]                  n_wq,
    output logic [NW-1:0]                  n_raddr,
    input  wire logic [NW-1:0]             n_rfail,
    input  wire logic [acm_pkg::CNT_W-1:0] n_rcnt,
    input  wire logic [NW-1:0]             n_rq
);

    localparam logic [CW-1:0] COL_LAST  = CW'(ALPHABET - 1);
    localparam logic [NW-1:0] NODE_FULL = NW'(MAX_NODES - 1);
    localparam logic [NW:0]   Q_DEPTH   = (NW+1)'(MAX_NODES);

    acm_pkg::acm_state_t state_reg, state_next;
    logic [NW-1:0]             ins_cur_reg, ins_cur_next;
    logic [NW-1:0]             scan_cur_reg, scan_cur_next;
    logic [NW-1:0]             total_reg, total_next;
    logic                      built_reg, built_next;
    logic                      last_reg, last_next;
    logic                      pend_reg, pend_next;
    logic [NW-1:0]             row_reg, row_next;
    logic [CW-1:0]             col_reg, col_next;
    logic [NW:0]               head_reg, head_next;
    logic [NW:0]               tail_reg, tail_next;
    logic [NW-1:0]             p_reg, p_next;
    logic [NW-1:0]             f_reg, f_next;
    logic [acm_pkg::CNT_W-1:0] cntp_reg, cntp_next;
    logic [acm_pkg::CNT_W-1:0] rcount_reg, rcount_next;
    logic [NW-1:0]             rnode_reg, rnode_next;
    logic                      rstatus_reg, rstatus_next;
    logic                      sym_ok;
    logic [NW-1:0]             via;
    logic [NW-1:0]             new_node;

    function automatic logic [GW-1:0] gaddr(input logic [NW-1:0] n, input logic [CW-1:0] c);
        return GW'(n) * GW'(ALPHABET) + GW'(c);
    endfunction

    assign sym_ok     = 32'(symbol) < ALPHABET;
    assign via        = (p_reg != '0) ? g_rdata_b : '0;
    assign new_node   = total_reg + NW'(1);
    assign res_count  = rcount_reg;
    assign res_node   = rnode_reg;
    assign res_status = rstatus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= acm_pkg::ST_SWEEP;
            ins_cur_reg  <= '0;
            scan_cur_reg <= '0;
            total_reg    <= '0;
            built_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ins_cur_reg  <= ins_cur_next;
            scan_cur_reg <= scan_cur_next;
            total_reg    <= total_next;
            built_reg    <= built_next;
            pend_reg     <= pend_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        p_reg       <= p_next;
        f_reg       <= f_next;
        cntp_reg    <= cntp_next;
        rcount_reg  <= rcount_next;
        rnode_reg   <= rnode_next;
        rstatus_reg <= rstatus_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        ins_cur_next  = ins_cur_reg;
        scan_cur_next = scan_cur_reg;
        total_next    = total_reg;
        built_next    = built_reg;
        last_next     = last_reg;
        pend_next     = pend_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        p_next        = p_reg;
        f_next        = f_reg;
        cntp_next     = cntp_reg;
        rcount_next   = rcount_reg;
        rnode_next    = rnode_reg;
        rstatus_next  = rstatus_reg;
        item_ready    = 1'b0;
        res_load      = 1'b0;
        g_we          = 1'b0;
        g_waddr       = gaddr(row_reg, col_reg);
        g_wdata       = '0;
        g_raddr_a     = gaddr(p_reg, col_reg);
        g_raddr_b     = gaddr(f_reg, col_reg);
        n_we          = '0;
        n_waddr       = row_reg;
        n_wfail       = '0;
        n_wcnt        = '0;
        n_wq          = '0;
        n_raddr       = row_reg;

        case (state_reg)
            acm_pkg::ST_SWEEP:
            begin
                g_we = 1'b1;
                if (row_reg == '0)
                begin
                    // root entry of the node memory is zeroed with its row
                    n_we.fail = 1'b1;
                    n_we.cnt  = 1'b1;
                end
                if (col_reg == COL_LAST)
                begin
                    col_next   = '0;
                    state_next = pend_reg ? acm_pkg::ST_DONE : acm_pkg::ST_IDLE;
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end

            acm_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    col_next     = CW'(symbol);
                    last_next    = last;
                    rcount_next  = '0;
                    rnode_next   = '0;
                    rstatus_next = 1'b0;
                    case (kind)
                        acm_pkg::KIND_CLEAR:
                        begin
                            total_next    = '0;
                            ins_cur_next  = '0;
                            scan_cur_next = '0;
                            built_next    = 1'b0;
                            row_next      = '0;
                            col_next      = '0;
                            pend_next     = 1'b1;
                            state_next    = acm_pkg::ST_SWEEP;
                        end
                        acm_pkg::KIND_INSERT:
                        begin
                            if (built_reg || !sym_ok)
                            begin
                                rnode_next   = ins_cur_reg;
                                rstatus_next = built_reg;
                                if (last)
                                begin
                                    ins_cur_next = '0;
                                end
                                state_next = acm_pkg::ST_DONE;
                            end
                            else
                            begin
                                g_raddr_a  = gaddr(ins_cur_reg, CW'(symbol));
                                state_next = acm_pkg::ST_INS_CHK;
                            end
                        end
                        acm_pkg::KIND_BUILD:
                        begin
                            ins_cur_next  = '0;
                            scan_cur_next = '0;
                            if (built_reg)
                            begin
                                state_next = acm_pkg::ST_DONE;
                            end
                            else
                            begin
                                n_we.q     = 1'b1;
                                n_waddr    = '0;
                                head_next  = '0;
                                tail_next  = (NW+1)'(1);
                                state_next = acm_pkg::ST_B_POP;
                            end
                        end
                        default:
                        begin
                            if (!sym_ok)
                            begin
                                scan_cur_next = '0;
                                state_next    = acm_pkg::ST_DONE;
                            end
                            else
                            begin
                                g_raddr_a  = gaddr(scan_cur_reg, CW'(symbol));
                                state_next = acm_pkg::ST_SCAN_G;
                            end
                        end
                    endcase
                end
            end

            acm_pkg::ST_INS_CHK:
            begin
                if (g_rdata_a != '0)
                begin
                    rnode_next = g_rdata_a;
                    if (last_reg)
                    begin
                        n_raddr    = g_rdata_a;
                        row_next   = g_rdata_a;
                        state_next = acm_pkg::ST_INS_CNT;
                    end
                    else
                    begin
                        ins_cur_next = g_rdata_a;
                        state_next   = acm_pkg::ST_DONE;
                    end
                end
                else if (total_reg == NODE_FULL)
                begin
                    rstatus_next = 1'b1;
                    rnode_next   = ins_cur_reg;
                    if (last_reg)
                    begin
                        ins_cur_next = '0;
                    end
                    state_next = acm_pkg::ST_DONE;
                end
                else
                begin
                    // new node: link it, zero its failure link, set its count, then sweep its row
                    total_next = new_node;
                    g_we       = 1'b1;
                    g_waddr    = gaddr(ins_cur_reg, col_reg);
                    g_wdata    = new_node;
                    n_we.fail  = 1'b1;
                    n_we.cnt   = 1'b1;
                    n_waddr    = new_node;
                    n_wcnt     = acm_pkg::CNT_W'(last_reg);
                    rnode_next   = new_node;
                    ins_cur_next = last_reg ? '0 : new_node;
                    row_next     = new_node;
                    col_next     = '0;
                    pend_next    = 1'b1;
                    state_next   = acm_pkg::ST_SWEEP;
                end
            end

            acm_pkg::ST_INS_CNT:
            begin
                n_we.cnt     = 1'b1;
                n_wcnt       = acm_pkg::sat_add(n_rcnt, acm_pkg::CNT_W'(1));
                ins_cur_next = '0;
                state_next   = acm_pkg::ST_DONE;
            end

            acm_pkg::ST_SCAN_G:
            begin
                scan_cur_next = g_rdata_a;
                rnode_next    = g_rdata_a;
                n_raddr       = g_rdata_a;
                state_next    = acm_pkg::ST_SCAN_N;
            end

            acm_pkg::ST_SCAN_N:
            begin
                rcount_next = n_rcnt;
                state_next  = acm_pkg::ST_DONE;
            end

            acm_pkg::ST_B_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next = 1'b1;
                    state_next = acm_pkg::ST_DONE;
                end
                else
                begin
                    n_raddr    = head_reg[NW-1:0];
                    head_next  = head_reg + (NW+1)'(1);
                    state_next = acm_pkg::ST_B_P;
                end
            end

            acm_pkg::ST_B_P:
            begin
                p_next     = n_rq;
                n_raddr    = n_rq;
                state_next = acm_pkg::ST_B_F;
            end

            acm_pkg::ST_B_F:
            begin
                f_next    = n_rfail;
                cntp_next = n_rcnt;
                n_raddr   = n_rfail;
                col_next  = '0;
                state_next = (p_reg != '0) ? acm_pkg::ST_B_FC : acm_pkg::ST_B_C0;
            end

            acm_pkg::ST_B_FC:
            begin
                // failure node is shallower, so its count is already final
                n_we.cnt   = 1'b1;
                n_waddr    = p_reg;
                n_wcnt     = acm_pkg::sat_add(cntp_reg, n_rcnt);
                state_next = acm_pkg::ST_B_C0;
            end

            acm_pkg::ST_B_C0:
            begin
                state_next = acm_pkg::ST_B_C1;
            end

            acm_pkg::ST_B_C1:
            begin
                if (g_rdata_a != '0)
                begin
                    n_we.fail  = 1'b1;
                    n_waddr    = g_rdata_a;
                    n_wfail    = via;
                    row_next   = g_rdata_a;
                    state_next = acm_pkg::ST_B_C2;
                end
                else
                begin
                    g_we    = 1'b1;
                    g_waddr = gaddr(p_reg, col_reg);
                    g_wdata = via;
                    if (col_reg == COL_LAST)
                    begin
                        state_next = acm_pkg::ST_B_POP;
                    end
                    else
                    begin
                        col_next   = col_reg + CW'(1);
                        state_next = acm_pkg::ST_B_C0;
                    end
                end
            end

            acm_pkg::ST_B_C2:
            begin
                if (tail_reg < Q_DEPTH)
                begin
                    n_we.q    = 1'b1;
                    n_waddr   = tail_reg[NW-1:0];
                    n_wq      = row_reg;
                    tail_next = tail_reg + (NW+1)'(1);
                end
                if (col_reg == COL_LAST)
                begin
                    state_next = acm_pkg::ST_B_POP;
                end
                else
                begin
                    col_next   = col_reg + CW'(1);
                    state_next = acm_pkg::ST_B_C0;
                end
            end

            acm_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    res_load   = 1'b1;
                    pend_next  = 1'b0;
                    state_next = acm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = acm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/aho_corasick_matcher_unit.sv]
// top level of the aho-corasick multi-pattern matcher
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------
//  item     | item_valid / item_ready     | kind, symbol, last
//  result   | result_valid / result_ready | match_count, node, status
//
// scan: transition read, count read, result load; an out-of-alphabet letter
// goes straight to the load; insert: transition check, then a count update or
// a row sweep for a new node; clear: root row sweep; build: per queued node a
// pop, parent and failure reads and, below the root, a count update, then per
// letter a transition read and a link or queue write; a repeated build only
// loads its result. after reset a root row sweep runs with item_ready low.
// one item is in work at a time; the result register lets the next item be
// taken while the previous result still waits for result_ready.
`timescale 1ns / 1ps
`default_nettype none
module aho_corasick_matcher_unit #(
    parameter int MAX_NODES = 4096,
    parameter int ALPHABET  = 26
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [4:0]  symbol,
    input  wire logic        last,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [15:0]      match_count,
    output logic [11:0]      node,
    output logic             status
);

    // node index, letter index and transition address widths
    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(ALPHABET);
    localparam int GW = $clog2(MAX_NODES * ALPHABET);

    logic                      slot_free;
    logic                      res_load;
    logic [acm_pkg::CNT_W-1:0] res_count;
    logic [NW-1:0]             res_node;
    logic                      res_status;

    logic          g_we;
    logic [GW-1:0] g_waddr;
    logic [NW-1:0] g_wdata;
    logic [GW-1:0] g_raddr_a;
    logic [GW-1:0] g_raddr_b;
    logic [NW-1:0] g_rdata_a;
    logic [NW-1:0] g_rdata_b;

    acm_pkg::node_we_t         n_we;
    logic [NW-1:0]             n_waddr;
    logic [NW-1:0]             n_wfail;
    logic [acm_pkg::CNT_W-1:0] n_wcnt;
    logic [NW-1:0]             n_wq;
    logic [NW-1:0]             n_raddr;
    logic [NW-1:0]             n_rfail;
    logic [acm_pkg::CNT_W-1:0] n_rcnt;
    logic [NW-1:0]             n_rq;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] count_reg;
    logic [11:0] node_reg;
    logic        status_reg;

    // transition table: one row of ALPHABET next-node entries per node
    acm_goto_mem #(
        .DEPTH (MAX_NODES * ALPHABET),
        .AW    (GW),
        .DW    (NW)
    ) u_goto (
        .clk     (clk),
        .we      (g_we),
        .waddr   (g_waddr),
        .wdata   (g_wdata),
        .raddr_a (g_raddr_a),
        .raddr_b (g_raddr_b),
        .rdata_a (g_rdata_a),
        .rdata_b (g_rdata_b)
    );

    // failure link, pattern count and bfs queue slot per node
    acm_node_mem #(
        .DEPTH (MAX_NODES),
        .AW    (NW)
    ) u_node (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wfail (n_wfail),
        .wcnt  (n_wcnt),
        .wq    (n_wq),
        .raddr (n_raddr),
        .rfail (n_rfail),
        .rcnt  (n_rcnt),
        .rq    (n_rq)
    );

    acm_seq #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET),
        .NW        (NW),
        .CW        (CW),
        .GW        (GW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .kind       (kind),
        .symbol     (symbol),
        .last       (last),
        .slot_free  (slot_free),
        .res_load   (res_load),
        .res_count  (res_count),
        .res_node   (res_node),
        .res_status (res_status),
        .g_we       (g_we),
        .g_waddr    (g_waddr),
        .g_wdata    (g_wdata),
        .g_raddr_a  (g_raddr_a),
        .g_raddr_b  (g_raddr_b),
        .g_rdata_a  (g_rdata_a),
        .g_rdata_b  (g_rdata_b),
        .n_we       (n_we),
        .n_waddr    (n_waddr),
        .n_wfail    (n_wfail),
        .n_wcnt     (n_wcnt),
        .n_wq       (n_wq),
        .n_raddr    (n_raddr),
        .n_rfail    (n_rfail),
        .n_rcnt     (n_rcnt),
        .n_rq       (n_rq)
    );

    // result register: free when empty or its transfer completes this cycle
    assign slot_free = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload held until the transfer, no reset needed
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            count_reg  <= 16'(res_count);
            node_reg   <= 12'(res_node);
            status_reg <= res_status;
        end
    end

    assign result_valid = out_valid_reg;
    assign match_count  = count_reg;
    assign node         = node_reg;
    assign status       = status_reg;

`ifndef SYNTH
    // one item at a time: the sequencer is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while previous item still in work");

    // a result only appears when the sequencer loads one
    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(res_load))
        else $error("result appeared without a load");

    // a refused insert never reports matches
    a_status_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> match_count == 16'd0)
        else $error("refused symbol with nonzero match count");
`endif

endmodule
`default_nettype wire
